FILE: hw/rtl/dacs_pkg.sv
package dacs_pkg;

	localparam int WAITERS_DEF = 16;

	// func codes of an incoming request
	localparam logic [1:0] FN_REQUEST = 2'd0;
	localparam logic [1:0] FN_RELEASE = 2'd1;
	localparam logic [1:0] FN_CANCEL  = 2'd2;

	// result status codes
	localparam logic [2:0] ST_GRANTED  = 3'd0;
	localparam logic [2:0] ST_QUEUED   = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_IDLE     = 3'd3;
	localparam logic [2:0] ST_REMOVED  = 3'd4;
	localparam logic [2:0] ST_NOTFOUND = 3'd5;

	typedef struct packed {
		logic        tag;
		logic [7:0]  id;
		logic [15:0] track;
	} entry_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_APPEND,
		CMD_CANCEL,
		CMD_KILL
	} cmd_op_t;

	// command broadcast to every cell
	typedef struct packed {
		cmd_op_t     op;
		logic        tag;
		logic [7:0]  id;
		logic [15:0] track;
	} cmd_t;

	// running minimum handed from cell to cell
	typedef struct packed {
		logic        act;
		logic        found;
		logic [15:0] track;
		logic [7:0]  id;
	} wave_t;

endpackage

FILE: hw/rtl/dacs_cell.sv
module dacs_cell import dacs_pkg::*; #(
	parameter int WAITERS = WAITERS_DEF,
	parameter int IDX     = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmd_t                       cmd,
	input  logic [$clog2(WAITERS)-1:0] kill_idx,
	input  logic                       search_tag,
	input  logic                       prev_valid,
	input  logic                       next_valid,
	input  entry_t                     next_entry,
	input  wave_t                      wave_in,
	input  logic [$clog2(WAITERS)-1:0] wave_idx_in,
	output logic                       valid,
	output entry_t                     entry,
	output logic                       match,
	output wave_t                      wave_out,
	output logic [$clog2(WAITERS)-1:0] wave_idx_out
);

	localparam int IW = $clog2(WAITERS);
	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic   valid_q;
	entry_t entry_q;
	wave_t  wave_q;
	logic [IW-1:0] widx_q;
	logic   better;

	assign valid        = valid_q;
	assign entry        = entry_q;
	assign match        = valid_q && (entry_q.id == cmd.id);
	assign wave_out     = wave_q;
	assign wave_idx_out = widx_q;

	// strict less keeps the earliest entry on equal tracks
	assign better = wave_in.act && valid_q && (entry_q.tag == search_tag) &&
		(!wave_in.found || (entry_q.track < wave_in.track));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.op == CMD_APPEND && !valid_q && prev_valid) begin
			valid_q <= 1'b1;
		end else if (cmd.op == CMD_CANCEL && match) begin
			valid_q <= 1'b0;
		end else if (cmd.op == CMD_KILL && kill_idx == MY_IDX) begin
			valid_q <= 1'b0;
		end else if (!valid_q && next_valid) begin
			valid_q <= 1'b1;
		end else if (valid_q && !prev_valid) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == CMD_APPEND && !valid_q && prev_valid) begin
			entry_q <= '{tag: cmd.tag, id: cmd.id, track: cmd.track};
		end else if (!valid_q && next_valid) begin
			entry_q <= next_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q <= '0;
			widx_q <= '0;
		end else begin
			wave_q.act <= wave_in.act;
			if (better) begin
				wave_q.found <= 1'b1;
				wave_q.track <= entry_q.track;
				wave_q.id    <= entry_q.id;
				widx_q       <= MY_IDX;
			end else begin
				wave_q.found <= wave_in.found;
				wave_q.track <= wave_in.track;
				wave_q.id    <= wave_in.id;
				widx_q       <= wave_idx_in;
			end
		end
	end

endmodule

FILE: hw/rtl/disk_arm_cscan_scheduler.sv
// C-SCAN disk arm arbiter.
// Input channel (in_valid/in_ready) carries one request: func, requester_id,
// track. Output channel (out_valid/out_ready) returns exactly one result per
// request: status, grant_valid, grant_id, grant_track, busy_res.
// Waiters sit in a chain of WAITERS cells kept compacted in arrival order.
// request (grant, queue, reject) and unused func: the result is registered at
//   accept and the scheduler stays idle, ready for the next request.
// release: a search wave walks the chain one cell per cycle, one pass over all
//   cells, two passes when the current sweep is empty; the granted cell is
//   then removed and the chain closes the gap before the next request is taken.
// cancel: the result is registered at accept, then the chain compacts before
//   the next request is taken.
// The chain walk and the one-cell-per-cycle compaction decide how long
// release and cancel keep the input channel closed.
// Reset (arst_n low) empties the store, makes the disk idle, zeroes the
// current track and sweep phase. No clearing pass is needed.
// If the receiver stalls, the result holds in the output register and no
// new request is accepted until it is taken or taken in the same cycle.
module disk_arm_cscan_scheduler import dacs_pkg::*; #(
	parameter int WAITERS = WAITERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [7:0]  requester_id,
	input  logic [15:0] track,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic        grant_valid,
	output logic [7:0]  grant_id,
	output logic [15:0] grant_track,
	output logic        busy_res
);

	localparam int IW = $clog2(WAITERS);

	typedef enum logic [2:0] {
		S_IDLE    = 3'b001,
		S_WAVE    = 3'b010,
		S_COMPACT = 3'b100
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic [15:0] cur_track_q;
	logic   phase_q;
	logic   stag_q;      // tag being searched by the wave
	logic   wave_go_q;   // launches the wave into cell 0
	logic   pass_q;      // second pass after a sweep swap

	logic        out_valid_q;
	logic [2:0]  status_q;
	logic        gvalid_q;
	logic [7:0]  gid_q;
	logic [15:0] gtrack_q;
	logic        busy_res_q;

	// chain interconnect
	logic   valid_v  [WAITERS];
	entry_t entry_a  [WAITERS];
	logic   match_v  [WAITERS];
	wave_t  wave_a   [WAITERS];
	logic [IW-1:0] widx_a [WAITERS];

	cmd_t   cmd;
	logic [IW-1:0] kill_idx;
	logic   accept;
	logic   full;
	logic   hole;
	logic   cancel_hit;
	wave_t  wave_head;
	wave_t  wave_tail;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign full      = valid_v[WAITERS-1];
	assign wave_tail = wave_a[WAITERS-1];
	assign kill_idx  = widx_a[WAITERS-1];
	assign wave_head = '{act: wave_go_q, found: 1'b0, track: 16'd0, id: 8'd0};

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign grant_valid = gvalid_q;
	assign grant_id    = gid_q;
	assign grant_track = gtrack_q;
	assign busy_res    = busy_res_q;

	// a gap in the chain means compaction is still running; cancel_hit flags an id match in any cell
	always_comb begin
		hole       = 1'b0;
		cancel_hit = 1'b0;
		for (int i = 0; i < WAITERS - 1; i++) begin
			hole = hole | (!valid_v[i] & valid_v[i+1]);
		end
		for (int i = 0; i < WAITERS; i++) begin
			cancel_hit = cancel_hit | match_v[i];
		end
	end

	always_comb begin
		cmd.op    = CMD_NONE;
		cmd.tag   = (track >= cur_track_q) ? phase_q : ~phase_q;
		cmd.id    = requester_id;
		cmd.track = track;
		if (accept) begin
			case (func)
				FN_REQUEST: if (busy_q && !full) cmd.op = CMD_APPEND;
				FN_CANCEL:  cmd.op = CMD_CANCEL;
				default:    cmd.op = CMD_NONE;
			endcase
		end else if (state_q == S_WAVE && wave_tail.act && wave_tail.found) begin
			cmd.op = CMD_KILL;
		end
	end

	for (genvar g = 0; g < WAITERS; g++) begin : g_cell
		logic   prev_v;
		logic   next_v;
		entry_t next_e;
		wave_t  w_in;
		logic [IW-1:0] wi_in;

		if (g == 0) begin : g_head
			assign prev_v = 1'b1;
			assign w_in   = wave_head;
			assign wi_in  = '0;
		end else begin : g_body
			assign prev_v = valid_v[g-1];
			assign w_in   = wave_a[g-1];
			assign wi_in  = widx_a[g-1];
		end

		if (g == WAITERS - 1) begin : g_tail
			assign next_v = 1'b0;
			assign next_e = '0;
		end else begin : g_mid
			assign next_v = valid_v[g+1];
			assign next_e = entry_a[g+1];
		end

		dacs_cell #(
			.WAITERS (WAITERS),
			.IDX     (g)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cmd          (cmd),
			.kill_idx     (kill_idx),
			.search_tag   (stag_q),
			.prev_valid   (prev_v),
			.next_valid   (next_v),
			.next_entry   (next_e),
			.wave_in      (w_in),
			.wave_idx_in  (wi_in),
			.valid        (valid_v[g]),
			.entry        (entry_a[g]),
			.match        (match_v[g]),
			.wave_out     (wave_a[g]),
			.wave_idx_out (widx_a[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			busy_q      <= 1'b0;
			cur_track_q <= 16'd0;
			phase_q     <= 1'b0;
			stag_q      <= 1'b0;
			wave_go_q   <= 1'b0;
			pass_q      <= 1'b0;
			out_valid_q <= 1'b0;
			status_q    <= ST_NOTFOUND;
			gvalid_q    <= 1'b0;
			gid_q       <= 8'd0;
			gtrack_q    <= 16'd0;
			busy_res_q  <= 1'b0;
		end else begin
			wave_go_q <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						gvalid_q <= 1'b0;
						gid_q    <= 8'd0;
						gtrack_q <= 16'd0;
						case (func)
							FN_REQUEST: begin
								out_valid_q <= 1'b1;
								busy_res_q  <= 1'b1;
								if (!busy_q) begin
									busy_q      <= 1'b1;
									cur_track_q <= track;
									status_q    <= ST_GRANTED;
									gvalid_q    <= 1'b1;
									gid_q       <= requester_id;
									gtrack_q    <= track;
								end else if (full) begin
									status_q <= ST_FULL;
								end else begin
									status_q <= ST_QUEUED;
								end
							end
							FN_RELEASE: begin
								stag_q    <= phase_q;
								wave_go_q <= 1'b1;
								pass_q    <= 1'b0;
								state_q   <= S_WAVE;
							end
							FN_CANCEL: begin
								out_valid_q <= 1'b1;
								status_q    <= cancel_hit ? ST_REMOVED : ST_NOTFOUND;
								busy_res_q  <= busy_q;
								state_q     <= S_COMPACT;
							end
							default: begin
								out_valid_q <= 1'b1;
								status_q    <= ST_NOTFOUND;
								busy_res_q  <= busy_q;
							end
						endcase
					end
				end
				S_WAVE: begin
					if (wave_tail.act) begin
						if (wave_tail.found) begin
							// granted cell is killed this edge, chain closes the gap
							busy_q      <= 1'b1;
							cur_track_q <= wave_tail.track;
							out_valid_q <= 1'b1;
							status_q    <= ST_GRANTED;
							gvalid_q    <= 1'b1;
							gid_q       <= wave_tail.id;
							gtrack_q    <= wave_tail.track;
							busy_res_q  <= 1'b1;
							state_q     <= S_COMPACT;
						end else if (!pass_q) begin
							// current sweep empty: swap and search again
							phase_q   <= ~phase_q;
							stag_q    <= ~phase_q;
							wave_go_q <= 1'b1;
							pass_q    <= 1'b1;
						end else begin
							busy_q      <= 1'b0;
							out_valid_q <= 1'b1;
							status_q    <= ST_IDLE;
							busy_res_q  <= 1'b0;
							state_q     <= S_IDLE;
						end
					end
				end
				S_COMPACT: begin
					if (!hole) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
